FILE: src/bmpd_pkg.sv
// Shared constants, job codes and the job record for the BMP stream decoder.
package bmpd_pkg;

    localparam int DIM_BITS        = 16;
    localparam int PALETTE_ENTRIES = 256;
    localparam int HEADER_BYTES    = 54;
    localparam int PAL_IDX_BITS    = $clog2(PALETTE_ENTRIES);
    localparam int PAL_BYTE_BITS   = $clog2(4 * PALETTE_ENTRIES);
    localparam int HDR_IDX_BITS    = $clog2(HEADER_BYTES);
    localparam int QUEUE_DEPTH     = 4;
    localparam int QUEUE_PTR_BITS  = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS  = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0]  MAGIC_FIRST   = 8'h42;
    localparam logic [7:0]  MAGIC_SECOND  = 8'h4D;
    localparam logic [7:0]  INFO_SIZE     = 8'd40;
    localparam logic [15:0] DEPTH_TRUE    = 16'd24;
    localparam logic [15:0] DEPTH_INDEXED = 16'd8;
    localparam logic [31:0] CONSUMED_TRUE    = 32'(HEADER_BYTES);
    localparam logic [31:0] CONSUMED_INDEXED = 32'(HEADER_BYTES + 4 * PALETTE_ENTRIES);

    // Header byte offsets
    localparam int OFS_DATA   = 10;
    localparam int OFS_INFO   = 14;
    localparam int OFS_WIDTH  = 18;
    localparam int OFS_HEIGHT = 22;
    localparam int OFS_PLANES = 26;
    localparam int OFS_DEPTH  = 28;
    localparam int OFS_COMPR  = 30;
    localparam int OFS_COLORS = 46;

    localparam logic [1:0] KIND_HDR = 2'd0;
    localparam logic [1:0] KIND_PIX = 2'd1;
    localparam logic [1:0] KIND_ERR = 2'd2;

    typedef enum logic [2:0] {
        OP_HDR,
        OP_ERR,
        OP_PIX24,
        OP_PIX8,
        OP_PALW
    } t_op;

    typedef struct packed {
        t_op                     op;
        logic [PAL_IDX_BITS-1:0] addr;
        logic [23:0]             data;
        logic                    last;
        logic [15:0]             width;
        logic [15:0]             height;
        logic [4:0]              depth;
    } t_job;

endpackage

FILE: src/bmpd_front.sv
// Front end: parses the byte stream and issues jobs for the back end.
module bmpd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_data_byte,
    input  logic              i_start_of_file,
    output logic              o_job_push,
    output bmpd_pkg::t_job    o_job
);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_PALETTE,
        PH_SKIP,
        PH_PIXELS,
        PH_PAD,
        PH_DONE,
        PH_ERROR
    } t_phase;

    t_phase r_phase, n_phase;
    logic [bmpd_pkg::HDR_IDX_BITS-1:0]  r_hdr_idx, n_hdr_idx;
    logic                               r_bad, n_bad;
    logic [31:0]                        r_offset, n_offset;
    logic [31:0]                        r_width, n_width;
    logic [31:0]                        r_height, n_height;
    logic [15:0]                        r_depth, n_depth;
    logic [bmpd_pkg::PAL_BYTE_BITS-1:0] r_pal_idx, n_pal_idx;
    logic [15:0]                        r_partial, n_partial;
    logic [31:0]                        r_skip, n_skip;
    logic [bmpd_pkg::DIM_BITS-1:0]      r_col, n_col;
    logic [bmpd_pkg::DIM_BITS-1:0]      r_row, n_row;
    logic [1:0]                         r_bip, n_bip;
    logic [1:0]                         r_pad, n_pad;

    logic [7:0]                    b;
    int unsigned                   idx;
    logic                          final_bad;
    logic [31:0]                   consumed;
    logic                          pix;
    logic [1:0]                    tail;
    logic [bmpd_pkg::DIM_BITS-1:0] w_dim;
    logic [bmpd_pkg::DIM_BITS-1:0] h_dim;

    assign b     = i_data_byte;
    assign w_dim = r_width[bmpd_pkg::DIM_BITS-1:0];
    assign h_dim = r_height[bmpd_pkg::DIM_BITS-1:0];

    always_comb begin
        n_phase   = r_phase;
        n_hdr_idx = r_hdr_idx;
        n_bad     = r_bad;
        n_offset  = r_offset;
        n_width   = r_width;
        n_height  = r_height;
        n_depth   = r_depth;
        n_pal_idx = r_pal_idx;
        n_partial = r_partial;
        n_skip    = r_skip;
        n_col     = r_col;
        n_row     = r_row;
        n_bip     = r_bip;
        n_pad     = r_pad;
        idx       = 0;
        final_bad = 1'b0;
        consumed  = '0;
        pix       = 1'b0;
        tail      = '0;
        o_job_push    = 1'b0;
        o_job.op      = bmpd_pkg::OP_HDR;
        o_job.addr    = '0;
        o_job.data    = '0;
        o_job.last    = 1'b0;
        o_job.width   = r_width[15:0];
        o_job.height  = r_height[15:0];
        o_job.depth   = r_depth[4:0];
        if (i_accept) begin
            if (i_start_of_file) begin
                n_phase   = PH_HEADER;
                n_hdr_idx = '0;
                n_bad     = 1'b0;
                n_pal_idx = '0;
                n_skip    = '0;
                n_col     = '0;
                n_row     = '0;
                n_partial = '0;
                n_bip     = '0;
                n_pad     = '0;
            end
            case (n_phase)
                PH_HEADER: begin
                    idx = int'(n_hdr_idx);
                    // Capture fields a byte at a time and check fixed bytes on arrival
                    if (idx >= bmpd_pkg::OFS_DATA && idx < bmpd_pkg::OFS_DATA + 4)
                        n_offset[8*(idx-bmpd_pkg::OFS_DATA) +: 8] = b;
                    if (idx >= bmpd_pkg::OFS_WIDTH && idx < bmpd_pkg::OFS_WIDTH + 4)
                        n_width[8*(idx-bmpd_pkg::OFS_WIDTH) +: 8] = b;
                    if (idx >= bmpd_pkg::OFS_HEIGHT && idx < bmpd_pkg::OFS_HEIGHT + 4)
                        n_height[8*(idx-bmpd_pkg::OFS_HEIGHT) +: 8] = b;
                    if (idx >= bmpd_pkg::OFS_DEPTH && idx < bmpd_pkg::OFS_DEPTH + 2)
                        n_depth[8*(idx-bmpd_pkg::OFS_DEPTH) +: 8] = b;
                    if (idx == 0 && b != bmpd_pkg::MAGIC_FIRST) n_bad = 1'b1;
                    if (idx == 1 && b != bmpd_pkg::MAGIC_SECOND) n_bad = 1'b1;
                    if (idx == bmpd_pkg::OFS_INFO && b != bmpd_pkg::INFO_SIZE) n_bad = 1'b1;
                    if (idx > bmpd_pkg::OFS_INFO && idx < bmpd_pkg::OFS_INFO + 4 && b != 8'd0)
                        n_bad = 1'b1;
                    if (idx == bmpd_pkg::OFS_PLANES && b != 8'd1) n_bad = 1'b1;
                    if (idx == bmpd_pkg::OFS_PLANES + 1 && b != 8'd0) n_bad = 1'b1;
                    if (idx >= bmpd_pkg::OFS_COMPR && idx < bmpd_pkg::OFS_COMPR + 4 && b != 8'd0)
                        n_bad = 1'b1;
                    if (idx >= bmpd_pkg::OFS_COLORS && idx < bmpd_pkg::OFS_COLORS + 4
                            && b != 8'd0)
                        n_bad = 1'b1;
                    n_hdr_idx = n_hdr_idx + 1'b1;
                    if (idx == bmpd_pkg::HEADER_BYTES - 1) begin
                        final_bad = n_bad
                            || ((r_width >> bmpd_pkg::DIM_BITS) != 32'd0)
                            || ((r_height >> bmpd_pkg::DIM_BITS) != 32'd0)
                            || (r_depth != bmpd_pkg::DEPTH_TRUE
                                && r_depth != bmpd_pkg::DEPTH_INDEXED);
                        o_job_push = 1'b1;
                        if (final_bad) begin
                            n_phase  = PH_ERROR;
                            o_job.op = bmpd_pkg::OP_ERR;
                        end else begin
                            consumed = (r_depth == bmpd_pkg::DEPTH_INDEXED)
                                ? bmpd_pkg::CONSUMED_INDEXED : bmpd_pkg::CONSUMED_TRUE;
                            n_skip = (r_offset > consumed) ? r_offset - consumed : 32'd0;
                            n_col  = '0;
                            n_row  = '0;
                            if (r_width == 32'd0 || r_height == 32'd0) begin
                                n_phase    = PH_DONE;
                                o_job.last = 1'b1;
                            end else if (r_depth == bmpd_pkg::DEPTH_INDEXED) begin
                                n_phase = PH_PALETTE;
                            end else begin
                                n_phase = (n_skip != 32'd0) ? PH_SKIP : PH_PIXELS;
                            end
                        end
                    end
                end
                PH_PALETTE: begin
                    case (n_pal_idx[1:0])
                        2'd0: n_partial[7:0] = b;
                        2'd1: n_partial[15:8] = b;
                        2'd2: begin
                            o_job_push = 1'b1;
                            o_job.op   = bmpd_pkg::OP_PALW;
                            o_job.addr = n_pal_idx[bmpd_pkg::PAL_BYTE_BITS-1:2];
                            o_job.data = {b, n_partial};
                        end
                        default: ;
                    endcase
                    if (&n_pal_idx)
                        n_phase = (n_skip != 32'd0) ? PH_SKIP : PH_PIXELS;
                    n_pal_idx = n_pal_idx + 1'b1;
                end
                PH_SKIP: begin
                    n_skip = n_skip - 32'd1;
                    if (n_skip == 32'd0) n_phase = PH_PIXELS;
                end
                PH_PAD: begin
                    n_pad = n_pad - 2'd1;
                    if (n_pad == 2'd0) n_phase = PH_PIXELS;
                end
                PH_PIXELS: begin
                    if (r_depth == bmpd_pkg::DEPTH_INDEXED) begin
                        pix        = 1'b1;
                        o_job.op   = bmpd_pkg::OP_PIX8;
                        o_job.addr = b;
                    end else begin
                        case (n_bip)
                            2'd0: begin
                                n_partial[7:0] = b;
                                n_bip = 2'd1;
                            end
                            2'd1: begin
                                n_partial[15:8] = b;
                                n_bip = 2'd2;
                            end
                            default: begin
                                pix        = 1'b1;
                                o_job.op   = bmpd_pkg::OP_PIX24;
                                o_job.data = {b, n_partial};
                                n_bip      = 2'd0;
                                n_partial  = '0;
                            end
                        endcase
                    end
                    if (pix) begin
                        o_job_push = 1'b1;
                        if (n_col == w_dim - 1'b1) begin
                            n_col = '0;
                            if (n_row == h_dim - 1'b1) begin
                                n_phase    = PH_DONE;
                                o_job.last = 1'b1;
                            end else begin
                                n_row = n_row + 1'b1;
                                tail  = (r_depth == bmpd_pkg::DEPTH_INDEXED)
                                    ? w_dim[1:0] : 2'(w_dim[1:0] * 2'd3);
                                n_pad = 2'd0 - tail;
                                if (n_pad != 2'd0) n_phase = PH_PAD;
                            end
                        end else begin
                            n_col = n_col + 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HEADER;
            r_hdr_idx <= '0;
            r_bad     <= 1'b0;
            r_pal_idx <= '0;
            r_skip    <= '0;
            r_col     <= '0;
            r_row     <= '0;
            r_partial <= '0;
            r_bip     <= '0;
            r_pad     <= '0;
        end else begin
            r_phase   <= n_phase;
            r_hdr_idx <= n_hdr_idx;
            r_bad     <= n_bad;
            r_pal_idx <= n_pal_idx;
            r_skip    <= n_skip;
            r_col     <= n_col;
            r_row     <= n_row;
            r_partial <= n_partial;
            r_bip     <= n_bip;
            r_pad     <= n_pad;
        end
        r_offset <= n_offset;
        r_width  <= n_width;
        r_height <= n_height;
        r_depth  <= n_depth;
    end

endmodule

FILE: src/bmpd_fifo.sv
// Short job queue between the front and back ends.
module bmpd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bmpd_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output bmpd_pkg::t_job o_job,
    output logic           o_empty
);

    bmpd_pkg::t_job                      r_mem [bmpd_pkg::QUEUE_DEPTH];
    logic [bmpd_pkg::QUEUE_PTR_BITS-1:0] r_wr, r_rd;
    logic [bmpd_pkg::QUEUE_CNT_BITS-1:0] r_cnt;
    logic                                do_push, do_pop;

    assign o_full  = (r_cnt == bmpd_pkg::QUEUE_CNT_BITS'(bmpd_pkg::QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + 1'b1;
            if (do_pop) r_rd <= r_rd + 1'b1;
            if (do_push && !do_pop) r_cnt <= r_cnt + 1'b1;
            else if (do_pop && !do_push) r_cnt <= r_cnt - 1'b1;
        end
        if (do_push) r_mem[r_wr] <= i_job;
    end

endmodule

FILE: src/bmpd_back.sv
// Back end: palette memory, palette lookup and the result register.
module bmpd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  bmpd_pkg::t_job i_job,
    input  logic           i_job_empty,
    output logic           o_job_pop,
    output logic           empty,
    input  logic           pop,
    output logic [1:0]     o_kind,
    output logic [7:0]     o_channel_first,
    output logic [7:0]     o_channel_second,
    output logic [7:0]     o_channel_third,
    output logic [15:0]    o_image_width,
    output logic [15:0]    o_image_height,
    output logic [4:0]     o_bit_depth,
    output logic           o_last_pixel
);

    logic [23:0]    r_pal [bmpd_pkg::PALETTE_ENTRIES];
    logic [23:0]    r_rd_data;
    bmpd_pkg::t_job r_s1;
    logic           r_s1_valid;
    logic           r_out_valid;
    logic           out_free, s1_adv, s1_take, head_pal, s1_load;
    logic [23:0]    pix_data;

    assign out_free  = !r_out_valid || pop;
    assign s1_adv    = r_s1_valid && out_free;
    assign s1_take   = !r_s1_valid || out_free;
    assign head_pal  = !i_job_empty && (i_job.op == bmpd_pkg::OP_PALW);
    assign o_job_pop = !i_job_empty && (head_pal || s1_take);
    assign s1_load   = o_job_pop && !head_pal;
    assign empty     = !r_out_valid;
    assign pix_data  = (r_s1.op == bmpd_pkg::OP_PIX8) ? r_rd_data : r_s1.data;

    // Palette memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (o_job_pop && head_pal) r_pal[i_job.addr] <= i_job.data;
        if (s1_load) r_rd_data <= r_pal[i_job.addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_load) r_s1_valid <= 1'b1;
            else if (s1_adv) r_s1_valid <= 1'b0;
            if (s1_adv) r_out_valid <= 1'b1;
            else if (pop) r_out_valid <= 1'b0;
        end
        if (s1_load) r_s1 <= i_job;
        if (s1_adv) begin
            case (r_s1.op)
                bmpd_pkg::OP_HDR: o_kind <= bmpd_pkg::KIND_HDR;
                bmpd_pkg::OP_ERR: o_kind <= bmpd_pkg::KIND_ERR;
                default:          o_kind <= bmpd_pkg::KIND_PIX;
            endcase
            if (r_s1.op == bmpd_pkg::OP_PIX8 || r_s1.op == bmpd_pkg::OP_PIX24) begin
                o_channel_first  <= pix_data[7:0];
                o_channel_second <= pix_data[15:8];
                o_channel_third  <= pix_data[23:16];
            end else begin
                o_channel_first  <= '0;
                o_channel_second <= '0;
                o_channel_third  <= '0;
            end
            o_image_width  <= r_s1.width;
            o_image_height <= r_s1.height;
            o_bit_depth    <= r_s1.depth;
            o_last_pixel   <= r_s1.last;
        end
    end

endmodule

FILE: src/bmp_stream_decoder.sv
// Top level of the BMP stream decoder.
// Feed the file one byte per transaction: push with data and start_of_file;
// full low means the byte is taken. Raise start_of_file on the first byte of
// each file; it drops whatever file was in progress.
// Results leave through a queue-style port: while empty is low the oldest
// result is on the o_ ports, and pop takes it. Each result is a header
// accept, a pixel (blue, green, red in file order) or a format error.
// A byte that yields a result reaches the ports through the job queue entry,
// the stage-1 register and the result register; one byte is taken every
// cycle, limited only by the four-entry job queue and the result register.
// Indexed pixels read the 256-entry palette memory through one registered
// read port in the back end; palette loads pass through the same job queue,
// so a new file never overwrites entries still needed by queued pixels.
// When the receiver stalls, the result register holds, the back end takes
// only palette loads, the queue fills and full rises. Reset clears the
// parser, queue and result register; no memory clearing pass is needed.
module bmp_stream_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_start_of_file,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_channel_first,
    output logic [7:0]  o_channel_second,
    output logic [7:0]  o_channel_third,
    output logic [15:0] o_image_width,
    output logic [15:0] o_image_height,
    output logic [4:0]  o_bit_depth,
    output logic        o_last_pixel
);

    bmpd_pkg::t_job front_job, head_job;
    logic           front_push, q_full, q_empty, q_pop;

    assign full = q_full;

    bmpd_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (push && !q_full),
        .i_data_byte     (i_data_byte),
        .i_start_of_file (i_start_of_file),
        .o_job_push      (front_push),
        .o_job           (front_job)
    );

    bmpd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_job   (head_job),
        .o_empty (q_empty)
    );

    bmpd_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_job            (head_job),
        .i_job_empty      (q_empty),
        .o_job_pop        (q_pop),
        .empty            (empty),
        .pop              (pop),
        .o_kind           (o_kind),
        .o_channel_first  (o_channel_first),
        .o_channel_second (o_channel_second),
        .o_channel_third  (o_channel_third),
        .o_image_width    (o_image_width),
        .o_image_height   (o_image_height),
        .o_bit_depth      (o_bit_depth),
        .o_last_pixel     (o_last_pixel)
    );

endmodule

FILE: src/bmpd_checker.sv
// Port-level checks for the BMP stream decoder, bound to the top level.
module bmpd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        push,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [1:0]  o_kind,
    input logic [7:0]  o_channel_first,
    input logic [7:0]  o_channel_second,
    input logic [7:0]  o_channel_third,
    input logic [4:0]  o_bit_depth,
    input logic        o_last_pixel
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_kind == bmpd_pkg::KIND_HDR || o_kind == bmpd_pkg::KIND_PIX
                    || o_kind == bmpd_pkg::KIND_ERR))
        else $error("illegal result kind");

    a_no_color_on_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind != bmpd_pkg::KIND_PIX) |->
            (o_channel_first == 8'd0 && o_channel_second == 8'd0
             && o_channel_third == 8'd0))
        else $error("color bytes on header or error result");

    a_err_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind == bmpd_pkg::KIND_ERR) |-> !o_last_pixel)
        else $error("error result flagged as last pixel");

    a_good_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind != bmpd_pkg::KIND_ERR) |->
            (o_bit_depth == 5'd8 || o_bit_depth == 5'd24))
        else $error("accepted result with unsupported depth");

endmodule

bind bmp_stream_decoder bmpd_checker u_bmpd_checker (.*);

FILE: dv/bmp_checker.sv
// Checker for the BMP stream decoder: predicts results from input bytes and compares them.
`timescale 1ns / 1ps

module bmp_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_start_of_file,
    input  logic        i_empty,
    input  logic        i_pop,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_channel_first,
    input  logic [7:0]  i_channel_second,
    input  logic [7:0]  i_channel_third,
    input  logic [15:0] i_image_width,
    input  logic [15:0] i_image_height,
    input  logic [4:0]  i_bit_depth,
    input  logic        i_last_pixel,
    output int          o_fail_count,
    output int          o_pending
);

    typedef enum logic [2:0] {
        PH_HEADER, PH_PALETTE, PH_SKIP, PH_PIXELS, PH_PAD, PH_DONE, PH_ERROR
    } t_phase;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  ch0;
        logic [7:0]  ch1;
        logic [7:0]  ch2;
        logic [15:0] width;
        logic [15:0] height;
        logic [4:0]  depth;
        logic        last;
    } t_pixel_result;

    t_pixel_result expected_results[$];

    t_phase      phase;
    logic [7:0]  hdr[bmpd_pkg::HEADER_BYTES];
    logic [23:0] palette[bmpd_pkg::PALETTE_ENTRIES];
    int unsigned hdr_idx, pal_byte_idx, skip_left, col_cnt, row_cnt, pix_byte, pad_left;
    logic [15:0] pix_partial;

    assign o_pending = expected_results.size();

    function automatic logic [31:0] hdr_word(int off, int n);
        logic [31:0] v;
        v = '0;
        for (int i = 0; i < n; i++)
            v |= 32'(hdr[off + i]) << (8 * i);
        return v;
    endfunction

    function automatic t_pixel_result make_result(logic [1:0] kind, logic [23:0] bgr,
                                                  logic last);
        t_pixel_result r;
        r.kind   = kind;
        r.ch0    = bgr[7:0];
        r.ch1    = bgr[15:8];
        r.ch2    = bgr[23:16];
        r.width  = 16'(hdr_word(bmpd_pkg::OFS_WIDTH, 4));
        r.height = 16'(hdr_word(bmpd_pkg::OFS_HEIGHT, 4));
        r.depth  = 5'(hdr_word(bmpd_pkg::OFS_DEPTH, 2));
        r.last   = last;
        return r;
    endfunction

    task automatic restart();
        phase        = PH_HEADER;
        hdr_idx      = 0;
        pal_byte_idx = 0;
        skip_left    = 0;
        col_cnt      = 0;
        row_cnt      = 0;
        pix_partial  = '0;
        pix_byte     = 0;
        pad_left     = 0;
    endtask

    function automatic logic header_valid();
        logic [31:0] d;
        d = hdr_word(bmpd_pkg::OFS_DEPTH, 2);
        if (hdr[0] != bmpd_pkg::MAGIC_FIRST || hdr[1] != bmpd_pkg::MAGIC_SECOND) return 1'b0;
        if (hdr_word(bmpd_pkg::OFS_INFO, 4) != 32'(bmpd_pkg::INFO_SIZE)) return 1'b0;
        if (hdr_word(bmpd_pkg::OFS_WIDTH, 4) > 32'hFFFF
                || hdr_word(bmpd_pkg::OFS_HEIGHT, 4) > 32'hFFFF)
            return 1'b0;
        if (hdr_word(bmpd_pkg::OFS_PLANES, 2) != 32'd1) return 1'b0;
        if (d != 32'(bmpd_pkg::DEPTH_TRUE) && d != 32'(bmpd_pkg::DEPTH_INDEXED)) return 1'b0;
        if (hdr_word(bmpd_pkg::OFS_COMPR, 4) != 0) return 1'b0;
        if (hdr_word(bmpd_pkg::OFS_COLORS, 4) != 0) return 1'b0;
        return 1'b1;
    endfunction

    task automatic decode_byte(logic [7:0] b, logic sof);
        logic [31:0] w, h, d, consumed, ofs, tail;
        logic [23:0] bgr;
        if (sof) restart();
        w = hdr_word(bmpd_pkg::OFS_WIDTH, 4);
        h = hdr_word(bmpd_pkg::OFS_HEIGHT, 4);
        d = hdr_word(bmpd_pkg::OFS_DEPTH, 2);
        case (phase)
            PH_HEADER: begin
                hdr[hdr_idx] = b;
                hdr_idx++;
                if (hdr_idx < bmpd_pkg::HEADER_BYTES) return;
                w = hdr_word(bmpd_pkg::OFS_WIDTH, 4);
                h = hdr_word(bmpd_pkg::OFS_HEIGHT, 4);
                d = hdr_word(bmpd_pkg::OFS_DEPTH, 2);
                if (!header_valid()) begin
                    phase = PH_ERROR;
                    expected_results.push_back(make_result(bmpd_pkg::KIND_ERR, '0, 1'b0));
                    return;
                end
                consumed = (d == 32'(bmpd_pkg::DEPTH_INDEXED))
                    ? bmpd_pkg::CONSUMED_INDEXED : bmpd_pkg::CONSUMED_TRUE;
                ofs = hdr_word(bmpd_pkg::OFS_DATA, 4);
                skip_left = (ofs > consumed) ? ofs - consumed : 0;
                if (w == 0 || h == 0) begin
                    phase = PH_DONE;
                    expected_results.push_back(make_result(bmpd_pkg::KIND_HDR, '0, 1'b1));
                    return;
                end
                if (d == 32'(bmpd_pkg::DEPTH_INDEXED)) phase = PH_PALETTE;
                else phase = (skip_left != 0) ? PH_SKIP : PH_PIXELS;
                expected_results.push_back(make_result(bmpd_pkg::KIND_HDR, '0, 1'b0));
            end
            PH_PALETTE: begin
                // drop the reserved fourth byte of each entry
                if (pal_byte_idx % 4 != 3)
                    palette[pal_byte_idx / 4][8 * (pal_byte_idx % 4) +: 8] = b;
                pal_byte_idx++;
                if (pal_byte_idx >= 4 * bmpd_pkg::PALETTE_ENTRIES)
                    phase = (skip_left != 0) ? PH_SKIP : PH_PIXELS;
            end
            PH_SKIP: begin
                if (skip_left != 0) skip_left--;
                if (skip_left == 0) phase = PH_PIXELS;
            end
            PH_PAD: begin
                if (pad_left != 0) pad_left--;
                if (pad_left == 0) phase = PH_PIXELS;
            end
            PH_PIXELS: begin
                if (d == 32'(bmpd_pkg::DEPTH_INDEXED)) begin
                    bgr = palette[b];
                end else begin
                    if (pix_byte < 2) begin
                        pix_partial[8 * pix_byte +: 8] = b;
                        pix_byte++;
                        return;
                    end
                    bgr = {b, pix_partial};
                    pix_byte = 0;
                    pix_partial = '0;
                end
                col_cnt++;
                if (col_cnt >= w) begin
                    col_cnt = 0;
                    row_cnt++;
                    if (row_cnt >= h) begin
                        phase = PH_DONE;
                        expected_results.push_back(make_result(bmpd_pkg::KIND_PIX, bgr, 1'b1));
                        return;
                    end
                    tail = (w * ((d == 32'(bmpd_pkg::DEPTH_INDEXED)) ? 1 : 3)) & 3;
                    pad_left = (4 - tail) & 3;
                    if (pad_left != 0) phase = PH_PAD;
                end
                expected_results.push_back(make_result(bmpd_pkg::KIND_PIX, bgr, 1'b0));
            end
            default: ;
        endcase
    endtask

    initial begin
        o_fail_count = 0;
        foreach (hdr[i]) hdr[i] = '0;
        foreach (palette[i]) palette[i] = '0;
        restart();
    end

    always @(posedge i_clk) begin
        t_pixel_result got, want;
        if (!i_rst_n) begin
            restart();
            expected_results.delete();
        end else begin
            if (i_push && !i_full) decode_byte(i_data_byte, i_start_of_file);
            if (i_pop && !i_empty) begin
                got = '{i_kind, i_channel_first, i_channel_second, i_channel_third,
                        i_image_width, i_image_height, i_bit_depth, i_last_pixel};
                if (expected_results.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%0t: unexpected result %p", $realtime, got);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("%0t: mismatch expected %p actual %p",
                                     $realtime, want, got);
                    end
                end
            end
        end
    end

endmodule

FILE: dv/tb_top.sv
// Top of the BMP stream decoder testbench: file stimulus, result draining and verdict.
`timescale 1ns / 1ps

module tb_top;

    // header corruptions applied by build_file
    typedef enum int {
        BAD_NONE, BAD_MAGIC, BAD_INFO, BAD_PLANES, BAD_DEPTH, BAD_COMPR, BAD_COLORS,
        BAD_WIDTH, BAD_HEIGHT
    } t_corrupt;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  i_data_byte = '0;
    logic        i_start_of_file = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic [1:0]  o_kind;
    logic [7:0]  o_channel_first, o_channel_second, o_channel_third;
    logic [15:0] o_image_width, o_image_height;
    logic [4:0]  o_bit_depth;
    logic        o_last_pixel;
    int          fail_count, pending;
    bit          send_bursty, drain_bursty;
    logic [7:0]  file_bytes[$];

    bmp_stream_decoder i_dut (.*);

    bmp_checker i_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .i_full(full),
        .i_data_byte(i_data_byte), .i_start_of_file(i_start_of_file),
        .i_empty(empty), .i_pop(pop), .i_kind(o_kind),
        .i_channel_first(o_channel_first), .i_channel_second(o_channel_second),
        .i_channel_third(o_channel_third), .i_image_width(o_image_width),
        .i_image_height(o_image_height), .i_bit_depth(o_bit_depth),
        .i_last_pixel(o_last_pixel), .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic send_byte(logic [7:0] b, logic sof);
        int gap;
        gap = send_bursty ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push            <= 1'b1;
        i_data_byte     <= b;
        i_start_of_file <= sof;
        do @(posedge i_clk); while (full);
    endtask

    // Send the built file; the first byte carries start_of_file unless told otherwise.
    task automatic send_file(bit with_sof, int keep);
        send_bursty = ($urandom_range(0, 3) == 0);
        foreach (file_bytes[i]) begin
            if (i >= keep) break;
            send_byte(file_bytes[i], with_sof && i == 0);
        end
    endtask

    task automatic put_le(int off, logic [31:0] v, int n);
        for (int i = 0; i < n; i++) file_bytes[off + i] = v[8 * i +: 8];
    endtask

    task automatic build_file(int depth, logic [31:0] w, logic [31:0] h,
                              t_corrupt bad, int ofs_mode);
        int consumed, ofs, bpp, pad;
        file_bytes.delete();
        repeat (bmpd_pkg::HEADER_BYTES) file_bytes.push_back(8'($urandom));
        consumed = (depth == 8) ? bmpd_pkg::HEADER_BYTES + 4 * bmpd_pkg::PALETTE_ENTRIES
                                : bmpd_pkg::HEADER_BYTES;
        case (ofs_mode)
            0: ofs = consumed;
            1: ofs = consumed + $urandom_range(1, 5);
            2: ofs = $urandom_range(0, consumed - 1);
            default: ofs = 32'hFFFF_FFF0 + $urandom_range(0, 15);
        endcase
        file_bytes[0] = bmpd_pkg::MAGIC_FIRST;
        file_bytes[1] = bmpd_pkg::MAGIC_SECOND;
        put_le(bmpd_pkg::OFS_DATA, ofs, 4);
        put_le(bmpd_pkg::OFS_INFO, 32'(bmpd_pkg::INFO_SIZE), 4);
        put_le(bmpd_pkg::OFS_WIDTH, w, 4);
        put_le(bmpd_pkg::OFS_HEIGHT, h, 4);
        put_le(bmpd_pkg::OFS_PLANES, 1, 2);
        put_le(bmpd_pkg::OFS_DEPTH, depth, 2);
        put_le(bmpd_pkg::OFS_COMPR, 0, 4);
        put_le(bmpd_pkg::OFS_COLORS, 0, 4);
        case (bad)
            BAD_MAGIC:  file_bytes[$urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
            BAD_INFO:   put_le(bmpd_pkg::OFS_INFO,
                               $urandom_range(0, 1) ? 32'd12 : 32'($urandom), 4);
            BAD_PLANES: put_le(bmpd_pkg::OFS_PLANES, $urandom_range(2, 65535), 2);
            BAD_DEPTH:  put_le(bmpd_pkg::OFS_DEPTH,
                               $urandom_range(0, 1) ? 32'd16 : 32'h0118, 2);
            BAD_COMPR:  put_le(bmpd_pkg::OFS_COMPR, 32'h1 << $urandom_range(0, 31), 4);
            BAD_COLORS: put_le(bmpd_pkg::OFS_COLORS, 32'h1 << $urandom_range(0, 31), 4);
            BAD_WIDTH:  put_le(bmpd_pkg::OFS_WIDTH, w | (32'h1 << $urandom_range(16, 31)), 4);
            BAD_HEIGHT: put_le(bmpd_pkg::OFS_HEIGHT, h | (32'h1 << $urandom_range(16, 31)), 4);
            default: ;
        endcase
        if (depth == 8)
            repeat (4 * bmpd_pkg::PALETTE_ENTRIES) file_bytes.push_back(8'($urandom));
        if (ofs_mode == 1) repeat (ofs - consumed) file_bytes.push_back(8'($urandom));
        bpp = (depth == 8) ? 1 : 3;
        pad = (4 - ((w * bpp) & 3)) & 3;
        if (w <= 16 && h <= 16)
            for (int r = 0; r < h; r++)
                repeat (w * bpp + pad) file_bytes.push_back(8'($urandom));
        // trailing bytes after the image are ignored by the block
        repeat ($urandom_range(0, 3)) file_bytes.push_back(8'($urandom));
    endtask

    // Result side: hold pop until a transaction, with random stalls between.
    initial begin
        int gap, cnt;
        cnt = 0;
        @(posedge i_rst_n);
        forever begin
            if (cnt % 40 == 0) drain_bursty = ($urandom_range(0, 2) == 0);
            gap = drain_bursty ? 0 : $urandom_range(0, 15);
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            cnt++;
        end
    end

    initial begin
        int sent, depth, sel, wait_cnt;
        t_corrupt bad;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: a file before any start_of_file, then the special headers.
        build_file(24, 2, 2, BAD_NONE, 0);
        send_file(1'b0, file_bytes.size());
        build_file(8, 3, 2, BAD_NONE, 1);
        send_file(1'b1, file_bytes.size());
        build_file(24, 16'hFFFF, 0, BAD_NONE, 3);
        send_file(1'b1, file_bytes.size());
        build_file(24, 0, 16'hFFFF, BAD_NONE, 0);
        send_file(1'b1, file_bytes.size());
        for (int k = BAD_MAGIC; k <= BAD_HEIGHT; k++) begin
            build_file(24, 16'hFFFF, 16'hFFFF, t_corrupt'(k), 0);
            send_file(1'b1, file_bytes.size());
        end
        build_file(24, 1, 1, BAD_NONE, 2);
        send_file(1'b1, file_bytes.size());
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);

        // Random: mostly well-formed files, some broken, cut short or noise.
        sent = 0;
        while (sent < 1400) begin
            sel = $urandom_range(0, 99);
            depth = ($urandom_range(0, 99) < 4) ? 8 : 24;
            if (sel < 5) begin
                repeat ($urandom_range(1, 20)) begin
                    send_byte(8'($urandom), 1'($urandom));
                    sent++;
                end
            end else begin
                bad = (sel < 80) ? BAD_NONE : t_corrupt'($urandom_range(BAD_MAGIC, BAD_HEIGHT));
                build_file(depth, $urandom_range(1, (depth == 8) ? 5 : 6),
                           $urandom_range(1, 4), bad, $urandom_range(0, 2));
                if (sel >= 90)
                    send_file(1'b1, $urandom_range(1, file_bytes.size() - 1));
                else
                    send_file(1'b1, file_bytes.size());
                sent += file_bytes.size();
            end
        end
        push <= 1'b0;

        wait_cnt = 0;
        while (pending != 0 && wait_cnt < 100000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (30) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
